>>> hw/rtl/jse_pkg.sv
// ----------------------------------------------------------------------------
// jse_pkg
// Shared types, codes and byte encoders for the JSON string escaper.
// ----------------------------------------------------------------------------
package jse_pkg;

    localparam int QueueDepthDefault = 4;

    localparam int CodeW = 21;

    // Kind of the main part of a job
    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_UTF8  = 3'd1;
    localparam logic [2:0] KIND_ESC2  = 3'd2;
    localparam logic [2:0] KIND_UESC  = 3'd3;
    localparam logic [2:0] KIND_CLOSE = 3'd4;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    localparam logic [CodeW-1:0] CP_REPLACEMENT = 21'h00FFFD;

    // One job: the bytes caused by one accepted input transaction
    typedef struct packed {
        logic             open_q;    // opening quote first
        logic             pre_fffd;  // flushed high surrogate as U+FFFD
        logic [2:0]       kind;
        logic [CodeW-1:0] value;     // code point, escape letter or control code
    } job_t;

    function automatic logic [7:0] hex_lower(input logic [3:0] n);
        logic [7:0] r;
        begin
            if (n < 4'd10) r = 8'h30 + {4'd0, n};
            else           r = 8'h57 + {4'd0, n};
            return r;
        end
    endfunction

    function automatic logic [2:0] utf8_len(input logic [CodeW-1:0] v);
        logic [2:0] r;
        begin
            if (v < 21'h80)         r = 3'd1;
            else if (v < 21'h800)   r = 3'd2;
            else if (v < 21'h10000) r = 3'd3;
            else                    r = 3'd4;
            return r;
        end
    endfunction

    function automatic logic [2:0] main_count(input logic [2:0] kind,
                                              input logic [CodeW-1:0] v);
        logic [2:0] r;
        begin
            case (kind)
                KIND_UTF8:  r = utf8_len(v);
                KIND_ESC2:  r = 3'd2;
                KIND_UESC:  r = 3'd6;
                KIND_CLOSE: r = 3'd1;
                default:    r = 3'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [CodeW-1:0] v,
                                             input logic [2:0] k);
        logic [2:0] n;
        logic [7:0] r;
        begin
            n = utf8_len(v);
            r = 8'h00;
            case (n)
                3'd1: r = v[7:0];
                3'd2: r = (k == 3'd0) ? {3'b110, v[10:6]} : {2'b10, v[5:0]};
                3'd3: begin
                    case (k)
                        3'd0:    r = {4'b1110, v[15:12]};
                        3'd1:    r = {2'b10, v[11:6]};
                        default: r = {2'b10, v[5:0]};
                    endcase
                end
                default: begin
                    case (k)
                        3'd0:    r = {5'b11110, v[20:18]};
                        3'd1:    r = {2'b10, v[17:12]};
                        3'd2:    r = {2'b10, v[11:6]};
                        default: r = {2'b10, v[5:0]};
                    endcase
                end
            endcase
            return r;
        end
    endfunction

    function automatic logic [7:0] main_byte(input logic [2:0] kind,
                                             input logic [CodeW-1:0] v,
                                             input logic [2:0] k);
        logic [7:0] r;
        begin
            case (kind)
                KIND_UTF8: r = utf8_byte(v, k);
                KIND_ESC2: r = (k == 3'd0) ? CH_BSLASH : v[7:0];
                KIND_UESC: begin
                    case (k)
                        3'd0:    r = CH_BSLASH;
                        3'd1:    r = CH_U;
                        3'd2:    r = CH_ZERO;
                        3'd3:    r = CH_ZERO;
                        3'd4:    r = hex_lower({3'd0, v[4]});
                        default: r = hex_lower(v[3:0]);
                    endcase
                end
                KIND_CLOSE: r = CH_QUOTE;
                default:    r = 8'h00;
            endcase
            return r;
        end
    endfunction

endpackage

>>> hw/rtl/jse_front.sv
// ----------------------------------------------------------------------------
// jse_front
// Takes code values, tracks quote/surrogate state, emits at most one job each.
// ----------------------------------------------------------------------------
module jse_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [23:0]                s_tdata,   // [20:0] code_value, zero fill above
    input  logic                       s_tuser,   // [0] func
    input  logic                       q_full,
    output logic                       q_push,
    output jse_pkg::job_t              q_job
);

    logic       quote_open_reg, quote_open_next;
    logic       high_pending_reg, high_pending_next;
    logic [9:0] held_high_bits_reg, held_high_bits_next;

    logic [jse_pkg::CodeW-1:0] code;
    logic                      is_high, is_low, accept;
    jse_pkg::job_t             job;

    assign code     = s_tdata[jse_pkg::CodeW-1:0];
    assign is_high  = (code[20:10] == 11'h036);
    assign is_low   = (code[20:10] == 11'h037);
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        job          = '0;
        job.open_q   = !quote_open_reg;
        job.kind     = jse_pkg::KIND_NONE;
        high_pending_next   = high_pending_reg;
        held_high_bits_next = held_high_bits_reg;
        quote_open_next     = quote_open_reg;
        if (s_tuser) begin
            job.pre_fffd        = high_pending_reg;
            job.kind            = jse_pkg::KIND_CLOSE;
            quote_open_next     = 1'b0;
            high_pending_next   = 1'b0;
            held_high_bits_next = 10'd0;
        end else begin
            quote_open_next = 1'b1;
            if (high_pending_reg && is_low) begin
                // join the pair into a supplementary code point
                job.kind  = jse_pkg::KIND_UTF8;
                job.value = 21'h10000 + {1'b0, held_high_bits_reg, code[9:0]};
                high_pending_next   = 1'b0;
                held_high_bits_next = 10'd0;
            end else begin
                job.pre_fffd        = high_pending_reg;
                high_pending_next   = is_high;
                held_high_bits_next = is_high ? code[9:0] : 10'd0;
                if (is_high) begin
                    job.kind = jse_pkg::KIND_NONE;
                end else if (is_low) begin
                    job.kind  = jse_pkg::KIND_UTF8;
                    job.value = jse_pkg::CP_REPLACEMENT;
                end else begin
                    case (code)
                        21'h22: begin job.kind = jse_pkg::KIND_ESC2; job.value = 21'h22; end
                        21'h5C: begin job.kind = jse_pkg::KIND_ESC2; job.value = 21'h5C; end
                        21'h0A: begin job.kind = jse_pkg::KIND_ESC2; job.value = 21'h6E; end
                        21'h0D: begin job.kind = jse_pkg::KIND_ESC2; job.value = 21'h72; end
                        21'h09: begin job.kind = jse_pkg::KIND_ESC2; job.value = 21'h74; end
                        21'h08: begin job.kind = jse_pkg::KIND_ESC2; job.value = 21'h62; end
                        21'h0C: begin job.kind = jse_pkg::KIND_ESC2; job.value = 21'h66; end
                        default: begin
                            if (code < 21'h20) begin
                                job.kind  = jse_pkg::KIND_UESC;
                                job.value = code;
                            end else begin
                                job.kind  = jse_pkg::KIND_UTF8;
                                job.value = (code > 21'h10FFFF) ? jse_pkg::CP_REPLACEMENT
                                                                : code;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // a held high surrogate with the quote already open causes no bytes
    assign q_push = accept && (job.open_q || job.pre_fffd ||
                               (job.kind != jse_pkg::KIND_NONE));
    assign q_job  = job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quote_open_reg     <= 1'b0;
            high_pending_reg   <= 1'b0;
            held_high_bits_reg <= 10'd0;
        end else if (accept) begin
            quote_open_reg     <= quote_open_next;
            high_pending_reg   <= high_pending_next;
            held_high_bits_reg <= held_high_bits_next;
        end
    end

endmodule

>>> hw/rtl/jse_fifo.sv
// ----------------------------------------------------------------------------
// jse_fifo
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module jse_fifo #(
    parameter int DEPTH = jse_pkg::QueueDepthDefault
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  jse_pkg::job_t push_job,
    input  logic          pop,
    output logic          full,
    output logic          head_valid,
    output jse_pkg::job_t head_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FullCount = CW'(DEPTH);

    jse_pkg::job_t  entries_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg, count_next;

    assign full       = (count_reg == FullCount);
    assign head_valid = (count_reg != '0);
    assign head_job   = entries_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !(pop && head_valid)) count_next = count_reg + 1'b1;
        else if (!push && pop && head_valid) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (push) entries_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= (wr_ptr_reg == LastAddr) ? '0 : wr_ptr_reg + 1'b1;
            if (pop && head_valid)
                rd_ptr_reg <= (rd_ptr_reg == LastAddr) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

>>> hw/rtl/jse_back.sv
// ----------------------------------------------------------------------------
// jse_back
// Serializes one job per run into escaped UTF-8 bytes, one per ready cycle.
// ----------------------------------------------------------------------------
module jse_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          head_valid,
    input  jse_pkg::job_t head_job,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,    // [7:0] out_byte
    output logic          m_tlast,
    output logic          m_tuser     // [0] string_done
);

    logic          cur_valid_reg, cur_valid_next;
    jse_pkg::job_t cur_job_reg, cur_job_next;
    logic [3:0]    idx_reg, idx_next;

    logic [2:0] prefix_len, mcnt, midx;
    logic [3:0] total;
    logic       last, done;
    logic [7:0] cur_byte;

    assign prefix_len = {2'd0, cur_job_reg.open_q} + (cur_job_reg.pre_fffd ? 3'd3 : 3'd0);
    assign mcnt       = jse_pkg::main_count(cur_job_reg.kind, cur_job_reg.value);
    assign total      = {1'b0, prefix_len} + {1'b0, mcnt};
    assign midx       = idx_reg[2:0] - prefix_len;
    assign last       = (idx_reg == total - 4'd1);
    assign done       = last && (cur_job_reg.kind == jse_pkg::KIND_CLOSE);

    always_comb begin
        if (cur_job_reg.open_q && idx_reg == 4'd0) begin
            cur_byte = jse_pkg::CH_QUOTE;
        end else if (idx_reg < {1'b0, prefix_len}) begin
            // replacement character EF BF BD
            case (idx_reg[2:0] - {2'd0, cur_job_reg.open_q})
                3'd0:    cur_byte = 8'hEF;
                3'd1:    cur_byte = 8'hBF;
                default: cur_byte = 8'hBD;
            endcase
        end else begin
            cur_byte = jse_pkg::main_byte(cur_job_reg.kind, cur_job_reg.value, midx);
        end
    end

    assign m_tvalid = cur_valid_reg;
    assign m_tdata  = cur_byte;
    assign m_tlast  = last;
    assign m_tuser  = done;

    // take the next job as soon as the last byte of this one goes out
    assign pop = head_valid && (!cur_valid_reg || (m_tready && last));

    always_comb begin
        cur_valid_next = cur_valid_reg;
        cur_job_next   = cur_job_reg;
        idx_next       = idx_reg;
        if (!cur_valid_reg || (m_tready && last)) begin
            cur_valid_next = head_valid;
            cur_job_next   = head_job;
            idx_next       = 4'd0;
        end else if (m_tready) begin
            idx_next = idx_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        cur_job_reg <= cur_job_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 4'd0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_idx_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (idx_reg < total))
        else $error("byte index beyond end of run");

    a_done_is_last_quote: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == jse_pkg::CH_QUOTE))
        else $error("string_done not on final quote byte");

    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && idx_reg == $past(idx_reg) + 4'd1))
        else $error("run did not advance by one byte");
`endif

endmodule

>>> hw/rtl/json_string_utf8_escaper_top.sv
// ----------------------------------------------------------------------------
// json_string_utf8_escaper_top
// Streams code values in and quoted, escaped UTF-8 JSON string bytes out.
// ----------------------------------------------------------------------------
// Each input transaction carries one code value (func = 0) or an end marker
// (func = 1) and produces zero to nine output bytes, the last of them marked
// with tlast; the closing quote also carries string_done in tuser. The front
// takes one input transaction per cycle into a QUEUE_DEPTH-entry job queue,
// and the back sends one byte per cycle while m_tready is high, so plain
// ASCII runs at one item per cycle then; an item of n bytes holds the output
// until all n are sent. Input stalls only on a full queue. A high surrogate
// with the string open is held and produces no bytes until the next input.
module json_string_utf8_escaper_top #(
    parameter int QUEUE_DEPTH = jse_pkg::QueueDepthDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [20:0] code_value, zero fill above
    input  logic        s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,   // last_of_run
    output logic        m_tuser    // [0] string_done
);

    logic          q_full, q_push, q_pop, q_head_valid;
    jse_pkg::job_t q_push_job, q_head_job;

    jse_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (q_push_job)
    );

    jse_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_push_job),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head_job   (q_head_job)
    );

    jse_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_job   (q_head_job),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule
